### rtl/core/prl_pkg.sv
package prl_pkg;

  localparam int LIST_DEPTH  = 8;
  localparam int NUM_PLAYERS = 4;

  localparam int PLAYER_W = 2;
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int FADEB_W  = 8;
  localparam int FADE_W   = 11;
  localparam int ACT_W    = 2;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int PIDX_W = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;

  localparam int IN_BITS   = PLAYER_W + ID_W + PRI_W + FADEB_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = PLAYER_W + ACT_W + ID_W + PRI_W + FADE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_NONE       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP       = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP_START = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef entry_t [LIST_DEPTH-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

### rtl/core/priority_request_list_top.sv
// result: registered into m_tdata when S_CALC completes and the output is free
// acceptance: a new transaction is taken only in S_IDLE, after the read then modify-write of a
//   player's list row in the single-port-per-side list memory; a held result stalls acceptance
// reset: rst is synchronous and active high; it empties every list (counts to zero),
//   list memory contents are not cleared and need no clearing pass
module priority_request_list_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // player, req_id, req_priority, fade_byte, zero pad
  input  logic [prl_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_player, action, start_id, start_priority, fade_time, zero pad
  output logic [prl_pkg::OUT_DATA_W-1:0]     m_tdata
);

  import prl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  logic state;

  logic                kind;
  logic [PLAYER_W-1:0] player;
  logic [ID_W-1:0]     req_id;
  logic [PRI_W-1:0]    req_pri;
  logic [FADEB_W-1:0]  fade_byte;

  logic [CNT_W-1:0] counts [NUM_PLAYERS];

  logic [ROW_W-1:0] rd_word;
  row_t             row;
  row_t             row_next;
  logic             we;

  logic [PIDX_W-1:0] s_pidx;
  logic [PIDX_W-1:0] pidx;
  logic              accept;
  logic              fire;
  logic              player_ok;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  match_pos;
  logic [CNT_W-1:0]  ge_pos;
  logic              found;
  logic [ACT_W-1:0]  act;
  logic [ID_W-1:0]   o_id;
  logic [PRI_W-1:0]  o_pri;
  logic [FADE_W-1:0] o_fade;
  logic [FADE_W-1:0] fade;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == S_CALC) && (!m_tvalid || m_tready);
  assign s_pidx   = PIDX_W'(s_tdata[PLAYER_W-1:0]);
  assign pidx     = PIDX_W'(player);
  assign player_ok = (int'(player) < NUM_PLAYERS);
  assign row      = row_t'(rd_word);
  assign fade     = {fade_byte, 3'b000};

  prl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_PLAYERS)
  ) u_list_ram (
    .clk   (clk),
    .we    (we && fire),
    .waddr (pidx),
    .wdata (ROW_W'(row_next)),
    .re    (accept),
    .raddr (s_pidx),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= s_tuser;
      player    <= s_tdata[PLAYER_W-1:0];
      req_id    <= s_tdata[PLAYER_W +: ID_W];
      req_pri   <= s_tdata[PLAYER_W+ID_W +: PRI_W];
      fade_byte <= s_tdata[PLAYER_W+ID_W+PRI_W +: FADEB_W];
    end
  end

  always_comb begin
    cnt = player_ok ? counts[pidx] : '0;
    if (cnt > CNT_W'(LIST_DEPTH)) begin
      cnt = CNT_W'(LIST_DEPTH);
    end
  end

  // first matching id and first slot whose priority the new one equals or beats, over all slots at once
  always_comb begin
    match_pos = cnt;
    ge_pos    = cnt;
    found     = 1'b0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < cnt && row[i].id == req_id) begin
        match_pos = CNT_W'(i);
        found     = 1'b1;
      end
      if (CNT_W'(i) < cnt && req_pri >= row[i].pri) begin
        ge_pos = CNT_W'(i);
      end
    end
  end

  always_comb begin
    row_next = row;
    cnt_next = cnt;
    we       = 1'b0;
    act      = ACT_NONE;
    o_id     = '0;
    o_pri    = '0;
    o_fade   = '0;
    if (!player_ok) begin
      act = ACT_NONE;
    end else if (kind == KIND_INSERT) begin
      if (found) begin
        if (match_pos == '0) begin
          act    = ACT_START;
          o_id   = req_id;
          o_pri  = req_pri;
          o_fade = fade;
        end
      end else if (ge_pos < CNT_W'(LIST_DEPTH)) begin
        we = 1'b1;
        if (cnt < CNT_W'(LIST_DEPTH)) begin
          cnt_next = cnt + 1'b1;
        end
        for (int i = 0; i < LIST_DEPTH; i++) begin
          if (CNT_W'(i) == ge_pos) begin
            row_next[i].id  = req_id;
            row_next[i].pri = req_pri;
          end else if (CNT_W'(i) > ge_pos && i > 0) begin
            row_next[i] = row[i-1];
          end
        end
        if (ge_pos == '0) begin
          act    = ACT_START;
          o_id   = req_id;
          o_pri  = req_pri;
          o_fade = fade;
        end
      end
    end else begin
      if (found) begin
        we       = 1'b1;
        cnt_next = cnt - 1'b1;
        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
          if (CNT_W'(i) >= match_pos) begin
            row_next[i] = row[i+1];
          end
        end
      end
      // head removed, or list already empty
      if (match_pos == '0) begin
        o_fade = fade;
        if (cnt_next != '0) begin
          act   = ACT_STOP_START;
          o_id  = row_next[0].id;
          o_pri = row_next[0].pri;
        end else begin
          act = ACT_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int p = 0; p < NUM_PLAYERS; p++) begin
        counts[p] <= '0;
      end
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (fire) begin
            state <= S_IDLE;
            if (we) begin
              counts[pidx] <= cnt_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_DATA_W'({o_fade, o_pri, o_id, act, player});
    end
  end

endmodule

### rtl/core/prl_ram.sv
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
